### rtl/core/dqs_pkg.sv
// shared types and field widths of the double-ended queue with search
`default_nettype none

package dqs_pkg;

  localparam int OP_W        = 3;
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + 1 + WORD_W + COUNT_W);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

### rtl/core/double_ended_queue_with_search.sv
// top level: bounded double-ended queue of signed words with linear search
`default_nettype none

// Bounded double-ended queue of DEPTH signed 32-bit words, kept as a ring in
// one memory with a front index and a word count. Each input word carries an
// operation in tuser (push front, push back, pop front, pop back, search,
// query; codes 6 and 7 act as a query) and a data word in tdata, and yields
// exactly one result word: status, search hit flag, popped word and the count
// after the operation (the count is reported modulo 128). A push, a query or
// a failed push/pop goes from idle straight to the done state; a pop passes
// through a read-wait state first. A search reads one stored entry per cycle
// through the memory's single read port, from the front, and stops at the
// first hit. One operation is processed at a time; the result sits in an
// output register so the next word is taken while it waits.

module double_ended_queue_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value_in
  input  wire logic [OP_W-1:0]        s_axis_tuser,  // [2:0] operation
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // [1:0] status, [2] found,
                                                     // [34:3] value_out,
                                                     // [41:35] entry_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POPW,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         front;
  logic [CNT_W-1:0]         count;
  logic                     pop_front_sel;
  logic signed [WORD_W-1:0] key;
  logic [IDX_W-1:0]         scan_ptr;
  logic [CNT_W-1:0]         scan_left;
  logic                     cmp_valid;
  status_t                  res_status;
  logic                     res_found;
  logic signed [WORD_W-1:0] res_value;

  logic                     accept;
  op_t                      in_op;
  logic signed [WORD_W-1:0] in_word;
  logic                     is_full;
  logic                     is_empty;
  logic                     out_free;
  logic [IDX_W-1:0]         front_dec;
  logic [IDX_W-1:0]         front_inc;
  logic [IDX_W-1:0]         back_pos;
  logic [IDX_W-1:0]         last_pos;
  logic [SUM_W-1:0]         back_sum;
  logic [SUM_W-1:0]         last_sum;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic signed [WORD_W-1:0] ram_rdata;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    ring_inc = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_t'(s_axis_tuser);
  assign in_word       = s_axis_tdata[WORD_W-1:0];
  assign is_full       = (count == CNT_FULL);
  assign is_empty      = (count == '0);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // ring positions: sums stay below twice the depth, so one subtract wraps
  always_comb begin
    front_dec = (front == '0) ? IDX_LAST : front - 1'b1;
    front_inc = ring_inc(front);
    back_sum  = SUM_W'(front) + SUM_W'(count);
    last_sum  = back_sum - 1'b1;
    back_pos  = (back_sum >= SUM_DEPTH) ? IDX_W'(back_sum - SUM_DEPTH) : IDX_W'(back_sum);
    last_pos  = (last_sum >= SUM_DEPTH) ? IDX_W'(last_sum - SUM_DEPTH) : IDX_W'(last_sum);
  end

  always_comb begin
    ram_we    = accept && !is_full &&
                (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK);
    ram_waddr = (in_op == OP_PUSH_FRONT) ? front_dec : back_pos;
    ram_re    = (accept && !is_empty &&
                 (in_op == OP_POP_FRONT || in_op == OP_POP_BACK)) ||
                (state == S_SCAN && scan_left != '0);
    if (state == S_SCAN) begin
      ram_raddr = scan_ptr;
    end else if (in_op == OP_POP_FRONT) begin
      ram_raddr = front;
    end else begin
      ram_raddr = last_pos;
    end
  end

  dqs_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      front         <= '0;
      count         <= '0;
      cmp_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in the done state a new word replaces the one leaving
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key           <= in_word;
            pop_front_sel <= (in_op == OP_POP_FRONT);
            res_status    <= ST_OK;
            res_found     <= 1'b0;
            res_value     <= '0;
            state         <= S_DONE;
            unique case (in_op)
              OP_PUSH_FRONT: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  front <= front_dec;
                  count <= count + 1'b1;
                end
              end
              OP_PUSH_BACK: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_POPW;
                end
              end
              OP_SEARCH: begin
                if (!is_empty) begin
                  scan_ptr  <= front;
                  scan_left <= count;
                  cmp_valid <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POPW: begin
          res_value <= ram_rdata;
          count     <= count - 1'b1;
          if (pop_front_sel) begin
            front <= front_inc;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // each read is compared in the cycle after it is issued, from the read register
          if (scan_left != '0) begin
            scan_ptr  <= ring_inc(scan_ptr);
            scan_left <= scan_left - 1'b1;
          end
          cmp_valid <= (scan_left != '0);
          if (cmp_valid && ram_rdata == key) begin
            res_found <= 1'b1;
            state     <= S_DONE;
          end else if (!cmp_valid && scan_left == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{OUT_PAD_W{1'b0}}, COUNT_W'(count), res_value,
                              res_found, res_status};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/dqs_ram.sv
// single-port-write, single-port-read word store with registered read data
`default_nettype none

module dqs_ram
  import dqs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [IDX_W-1:0]         waddr,
  input  wire logic signed [WORD_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [IDX_W-1:0]         raddr,
  output logic signed [WORD_W-1:0]      rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
